// ----- rtl/core/caller_allowlist_filter_top_defines.svh -----
// Assertion macros for the allow-list filter top level.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef CALLER_ALLOWLIST_FILTER_TOP_DEFINES_SVH
`define CALLER_ALLOWLIST_FILTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define CAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cal_pkg.sv -----
package cal_pkg;

    localparam int ID_W   = 5;
    localparam int CNT_W  = 6;
    localparam int TIME_W = 32;
    localparam int CD_W   = 16;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 4;
    localparam int CIDX_W = 2;

    localparam logic [CNT_W-1:0] MAX_ACCEPTS_RST = 6'd30;
    localparam logic             TRACK_NICK_RST  = 1'b0;
    localparam logic [CD_W-1:0]  COOLDOWN_RST    = 16'd60;

    localparam logic [CIDX_W-1:0] CFG_MAX_ACCEPTS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TRACK_NICK  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COOLDOWN    = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_LIST   = 3'd2,
        ACT_CHECK  = 3'd3,
        ACT_QUIT   = 3'd4,
        ACT_NICK   = 3'd5
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 4'd0,
        ST_FULL   = 4'd1,
        ST_EXIST  = 4'd2,
        ST_NOT    = 4'd3,
        ST_NOUSER = 4'd4,
        ST_PASS   = 4'd5,
        ST_DENY   = 4'd6,
        ST_ENTRY  = 4'd7,
        ST_END    = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LIST,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] max_accepts;
        logic             track_nick;
        logic [CD_W-1:0]  cooldown;
    } t_cfg;

endpackage

// ----- rtl/core/cal_ifs.sv -----
interface cal_req_if import cal_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   user_id;
    logic [ID_W-1:0]   other_id;
    logic              other_valid;
    logic              sender_local;
    logic              dest_has_mode;
    logic              sender_privileged;
    logic [TIME_W-1:0] now;

    modport source (
        output valid, action, user_id, other_id, other_valid, sender_local,
               dest_has_mode, sender_privileged, now,
        input  ready
    );
    modport sink (
        input  valid, action, user_id, other_id, other_valid, sender_local,
               dest_has_mode, sender_privileged, now,
        output ready
    );
endinterface

interface cal_rsp_if import cal_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic            notify;
    logic [ID_W-1:0] entry_id;
    logic            last;

    modport source (output valid, status, notify, entry_id, last, input ready);
    modport sink (input valid, status, notify, entry_id, last, output ready);
endinterface

interface cal_cfg_if import cal_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/cal_mem.sv -----
// Single-port-read, single-port-write memory with per-entry valid bits;
// an entry never written reads as zero.
module cal_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_wr_valid
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= i_wr_valid;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- rtl/core/cal_cfg_regs.sv -----
module cal_cfg_regs import cal_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cal_cfg_if.sink       i_cfg,
    output t_cfg          o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_accepts <= MAX_ACCEPTS_RST;
            r_cfg.track_nick  <= TRACK_NICK_RST;
            r_cfg.cooldown    <= COOLDOWN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAX_ACCEPTS: r_cfg.max_accepts <= i_cfg.data[CNT_W-1:0];
                CFG_TRACK_NICK:  r_cfg.track_nick  <= i_cfg.data[0];
                CFG_COOLDOWN:    r_cfg.cooldown    <= i_cfg.data;
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/cal_ctrl.sv -----
// Sequencer: issues memory reads, decides, writes back and drives results.
module cal_ctrl import cal_pkg::*; #(
    parameter int MAX_USERS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    cal_req_if.sink                              i_req,
    cal_rsp_if.source                            o_rsp,
    input  t_cfg                                 i_cfg,
    output logic                                 o_row_rd_en,
    output logic [$clog2(MAX_USERS)-1:0]         o_row_rd_addr,
    input  logic [MAX_USERS+CNT_W-1:0]           i_row_rd_data,
    output logic                                 o_row_wr_en,
    output logic [$clog2(MAX_USERS)-1:0]         o_row_wr_addr,
    output logic [MAX_USERS+CNT_W-1:0]           o_row_wr_data,
    output logic                                 o_time_rd_en,
    output logic [$clog2(MAX_USERS)-1:0]         o_time_rd_addr,
    input  logic [TIME_W-1:0]                    i_time_rd_data,
    output logic                                 o_time_wr_en,
    output logic [$clog2(MAX_USERS)-1:0]         o_time_wr_addr,
    output logic [TIME_W-1:0]                    o_time_wr_data,
    output logic                                 o_time_wr_valid
);

    localparam int AW = $clog2(MAX_USERS);
    localparam logic [ID_W:0]  NUM_IDS  = (ID_W+1)'(MAX_USERS);
    localparam logic [AW-1:0]  LAST_IDX = AW'(MAX_USERS - 1);

    t_state                r_state, n_state;
    t_action               r_act;
    logic [ID_W-1:0]       r_uid, r_oid;
    logic                  r_ovalid, r_local, r_mode, r_priv;
    logic [TIME_W-1:0]     r_now;
    logic [AW-1:0]         r_idx;
    logic [MAX_USERS-1:0]  r_mask;

    logic                  r_o_valid;
    t_status               r_o_status;
    logic                  r_o_notify;
    logic [ID_W-1:0]       r_o_entry;
    logic                  r_o_last;

    t_action               in_act;
    logic                  in_uok, in_ook;
    logic [AW-1:0]         in_uaddr, in_oaddr;
    logic                  acc, out_free;

    logic                  r_uok, r_ook;
    logic [AW-1:0]         uid_idx, oid_idx;
    logic [MAX_USERS-1:0]  ubit, obit;
    logic [MAX_USERS-1:0]  row_cur;
    logic [CNT_W-1:0]      cnt_cur;
    logic [TIME_W:0]       limit;
    logic                  late_enough, pass_early;
    logic [AW-1:0]         low_idx;

    logic                  push, load_mask;
    t_status               res_status;
    logic                  res_notify;
    logic [ID_W-1:0]       res_entry;
    logic                  res_last;

    // input side decode
    assign in_act   = t_action'(i_req.action);
    assign in_uok   = {1'b0, i_req.user_id} < NUM_IDS;
    assign in_ook   = {1'b0, i_req.other_id} < NUM_IDS;
    assign in_uaddr = in_uok ? AW'(i_req.user_id) : '0;
    assign in_oaddr = in_ook ? AW'(i_req.other_id) : '0;
    assign acc      = i_req.valid && i_req.ready;
    assign out_free = !r_o_valid || o_rsp.ready;

    // held item decode
    assign r_uok   = {1'b0, r_uid} < NUM_IDS;
    assign r_ook   = {1'b0, r_oid} < NUM_IDS;
    assign uid_idx = AW'(r_uid);
    assign oid_idx = AW'(r_oid);

    always_comb begin
        ubit = '0;
        obit = '0;
        if (r_uok) begin
            ubit[uid_idx] = 1'b1;
        end
        if (r_ook) begin
            obit[oid_idx] = 1'b1;
        end
    end

    assign row_cur     = i_row_rd_data[MAX_USERS-1:0];
    assign cnt_cur     = i_row_rd_data[MAX_USERS+CNT_W-1:MAX_USERS];
    assign limit       = {1'b0, i_time_rd_data} + (TIME_W+1)'(i_cfg.cooldown);
    assign late_enough = {1'b0, r_now} > limit;
    assign pass_early  = !r_local || !r_mode || (r_uid == r_oid) || r_priv;

    // lowest pending entry of the list walk
    always_comb begin
        low_idx = '0;
        for (int i = MAX_USERS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_idx = AW'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (in_act) inside
                        ACT_ADD, ACT_REMOVE, ACT_LIST, ACT_CHECK: n_state = S_EXEC;
                        ACT_QUIT: n_state = in_uok ? S_SWEEP : S_DONE;
                        ACT_NICK: n_state = (in_uok && !i_cfg.track_nick) ? S_SWEEP : S_DONE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                if (r_act == ACT_LIST) begin
                    n_state = S_LIST;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_free && (r_mask == '0)) begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready     = 1'b0;
        o_row_rd_en     = 1'b0;
        o_row_rd_addr   = '0;
        o_row_wr_en     = 1'b0;
        o_row_wr_addr   = '0;
        o_row_wr_data   = '0;
        o_time_rd_en    = 1'b0;
        o_time_rd_addr  = '0;
        o_time_wr_en    = 1'b0;
        o_time_wr_addr  = '0;
        o_time_wr_data  = '0;
        o_time_wr_valid = 1'b0;
        push            = 1'b0;
        load_mask       = 1'b0;
        res_status      = ST_OK;
        res_notify      = 1'b0;
        res_entry       = '0;
        res_last        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    case (in_act) inside
                        ACT_ADD, ACT_REMOVE, ACT_LIST: begin
                            o_row_rd_en   = 1'b1;
                            o_row_rd_addr = in_uaddr;
                        end
                        ACT_CHECK: begin
                            o_row_rd_en    = 1'b1;
                            o_row_rd_addr  = in_oaddr;
                            o_time_rd_en   = 1'b1;
                            o_time_rd_addr = in_oaddr;
                        end
                        ACT_QUIT: begin
                            // start the purge sweep and free the notify slot
                            o_row_rd_en    = in_uok;
                            o_time_wr_en   = in_uok;
                            o_time_wr_addr = in_uaddr;
                        end
                        ACT_NICK: begin
                            o_row_rd_en = in_uok && !i_cfg.track_nick;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EXEC: begin
                push = out_free && (r_act != ACT_LIST);
                case (r_act)
                    ACT_ADD: begin
                        if (!r_ovalid || !r_uok || !r_ook) begin
                            res_status = ST_NOUSER;
                        end else if (cnt_cur >= i_cfg.max_accepts) begin
                            res_status = ST_FULL;
                        end else if ((row_cur & obit) != '0) begin
                            res_status = ST_EXIST;
                        end else begin
                            o_row_wr_en   = out_free;
                            o_row_wr_addr = uid_idx;
                            o_row_wr_data = {cnt_cur + CNT_W'(1), row_cur | obit};
                        end
                    end
                    ACT_REMOVE: begin
                        if (!r_ovalid || !r_uok || !r_ook) begin
                            res_status = ST_NOUSER;
                        end else if ((row_cur & obit) == '0) begin
                            res_status = ST_NOT;
                        end else begin
                            o_row_wr_en   = out_free;
                            o_row_wr_addr = uid_idx;
                            o_row_wr_data = {cnt_cur - CNT_W'(1), row_cur & ~obit};
                        end
                    end
                    ACT_LIST: begin
                        load_mask = 1'b1;
                    end
                    ACT_CHECK: begin
                        if (pass_early) begin
                            res_status = ST_PASS;
                        end else if (!r_ook) begin
                            res_status = ST_DENY;
                        end else if ((row_cur & ubit) != '0) begin
                            res_status = ST_PASS;
                        end else begin
                            res_status = ST_DENY;
                            if (late_enough) begin
                                res_notify      = 1'b1;
                                o_time_wr_en    = out_free;
                                o_time_wr_addr  = oid_idx;
                                o_time_wr_data  = r_now;
                                o_time_wr_valid = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_LIST: begin
                push = out_free;
                if (r_mask != '0) begin
                    res_status = ST_ENTRY;
                    res_entry  = ID_W'(low_idx);
                    res_last   = 1'b0;
                end else begin
                    res_status = ST_END;
                end
            end
            S_SWEEP: begin
                // write back row r_idx while reading the next one
                o_row_wr_en   = 1'b1;
                o_row_wr_addr = r_idx;
                if ((r_act == ACT_QUIT) && (r_idx == uid_idx)) begin
                    o_row_wr_data = '0;
                end else if ((row_cur & ubit) != '0) begin
                    o_row_wr_data = {cnt_cur - CNT_W'(1), row_cur & ~ubit};
                end else begin
                    o_row_wr_data = {cnt_cur, row_cur};
                end
                if (r_idx != LAST_IDX) begin
                    o_row_rd_en   = 1'b1;
                    o_row_rd_addr = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                push = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_act    <= in_act;
            r_uid    <= i_req.user_id;
            r_oid    <= i_req.other_id;
            r_ovalid <= i_req.other_valid;
            r_local  <= i_req.sender_local;
            r_mode   <= i_req.dest_has_mode;
            r_priv   <= i_req.sender_privileged;
            r_now    <= i_req.now;
            r_idx    <= '0;
        end else if (r_state == S_SWEEP) begin
            r_idx <= r_idx + AW'(1);
        end
        if (load_mask) begin
            r_mask <= r_uok ? row_cur : '0;
        end else if ((r_state == S_LIST) && out_free && (r_mask != '0)) begin
            r_mask <= r_mask & (r_mask - MAX_USERS'(1));
        end
        if (push) begin
            r_o_status <= res_status;
            r_o_notify <= res_notify;
            r_o_entry  <= res_entry;
            r_o_last   <= res_last;
        end
    end

    assign o_rsp.valid    = r_o_valid;
    assign o_rsp.status   = r_o_status;
    assign o_rsp.notify   = r_o_notify;
    assign o_rsp.entry_id = r_o_entry;
    assign o_rsp.last     = r_o_last;

endmodule

// ----- rtl/core/caller_allowlist_filter_top.sv -----
// Channel   Dir  Payload                                         Handshake
// i_req     in   action, user_id, other_id, flags, now           valid/ready
// o_rsp     out  status, notify, entry_id, last                  valid/ready
// i_cfg     in   index (0 max_accepts, 1 track_nick, 2 cooldown)  valid/ready
//
// Add, remove and message check read a row (and notify time), then decide with
// write-back into the output register; a non-purging quit or nick only replies.
// List reads the row, then sends each entry and an end marker; a purge (quit, nick
// without tracking) sweeps every row; a stalled result holds the sequencer, sweep aside.
// Reset is synchronous; per-entry valid bits make every memory read as zero at once.
// The next request is taken on return to idle even while a result still waits.
`include "caller_allowlist_filter_top_defines.svh"

module caller_allowlist_filter_top import cal_pkg::*; #(
    parameter int MAX_USERS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cal_req_if.sink   i_req,
    cal_rsp_if.source o_rsp,
    cal_cfg_if.sink   i_cfg
);

    localparam int AW = $clog2(MAX_USERS);
    localparam int RW = MAX_USERS + CNT_W;

    t_cfg              cfg;

    // row memory: {entry count, allow bits} per owner
    logic              row_rd_en;
    logic [AW-1:0]     row_rd_addr;
    logic [RW-1:0]     row_rd_data;
    logic              row_wr_en;
    logic [AW-1:0]     row_wr_addr;
    logic [RW-1:0]     row_wr_data;

    // notify time memory: last notification per owner
    logic              time_rd_en;
    logic [AW-1:0]     time_rd_addr;
    logic [TIME_W-1:0] time_rd_data;
    logic              time_wr_en;
    logic [AW-1:0]     time_wr_addr;
    logic [TIME_W-1:0] time_wr_data;
    logic              time_wr_valid;

    // assertion terms
    logic              req_taken;
    logic              rsp_open;
    logic              rsp_notify;

    cal_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    cal_mem #(
        .WIDTH (RW),
        .DEPTH (MAX_USERS)
    ) u_row_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (row_rd_en),
        .i_rd_addr  (row_rd_addr),
        .o_rd_data  (row_rd_data),
        .i_wr_en    (row_wr_en),
        .i_wr_addr  (row_wr_addr),
        .i_wr_data  (row_wr_data),
        .i_wr_valid (1'b1)
    );

    cal_mem #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_USERS)
    ) u_time_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (time_rd_en),
        .i_rd_addr  (time_rd_addr),
        .o_rd_data  (time_rd_data),
        .i_wr_en    (time_wr_en),
        .i_wr_addr  (time_wr_addr),
        .i_wr_data  (time_wr_data),
        .i_wr_valid (time_wr_valid)
    );

    // reads and write-backs never target the same row in one cycle:
    // the sequencer holds one request at a time and the sweep reads ahead
    cal_ctrl #(
        .MAX_USERS (MAX_USERS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (i_req),
        .o_rsp           (o_rsp),
        .i_cfg           (cfg),
        .o_row_rd_en     (row_rd_en),
        .o_row_rd_addr   (row_rd_addr),
        .i_row_rd_data   (row_rd_data),
        .o_row_wr_en     (row_wr_en),
        .o_row_wr_addr   (row_wr_addr),
        .o_row_wr_data   (row_wr_data),
        .o_time_rd_en    (time_rd_en),
        .o_time_rd_addr  (time_rd_addr),
        .i_time_rd_data  (time_rd_data),
        .o_time_wr_en    (time_wr_en),
        .o_time_wr_addr  (time_wr_addr),
        .o_time_wr_data  (time_wr_data),
        .o_time_wr_valid (time_wr_valid)
    );

    // spare action codes are dropped in place and leave ready high
    assign req_taken  = i_req.valid && i_req.ready && (i_req.action <= ACT_NICK);
    assign rsp_open   = o_rsp.valid && !o_rsp.last;
    assign rsp_notify = o_rsp.valid && o_rsp.notify;

    // one request in flight: a taken request drops ready for the next cycle
    `CAL_ASSERT_NEXT(a_one_in_flight, req_taken, !i_req.ready, "request overlap")
    // only list entries leave an item open
    `CAL_ASSERT_NOW(a_open_is_entry, rsp_open, o_rsp.status == ST_ENTRY, "open non-entry")
    // notification goes only with a denied message
    `CAL_ASSERT_NOW(a_notify_deny, rsp_notify, o_rsp.status == ST_DENY, "notify w/o deny")

endmodule

// ----- tb/caller_allowlist_filter_top_test.sv -----
module caller_allowlist_filter_top_test;
    import cal_pkg::*;

    localparam int N_USERS          = 32;
    // Cycles to let pass once no reply is owed: covers a full purge sweep.
    localparam int CLOSE_GAP        = N_USERS + 8;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 30;

    // Action codes the block must ignore without a reply.
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [ID_W-1:0]   user_id;
        logic [ID_W-1:0]   other_id;
        logic              other_valid;
        logic              sender_local;
        logic              dest_has_mode;
        logic              sender_privileged;
        logic [TIME_W-1:0] now;
    } t_request;

    typedef struct {
        logic [ST_W-1:0] status;
        logic            notify;
        logic [ID_W-1:0] entry_id;
        logic            last;
    } t_reply;

    // Mirror of the allow matrix, counts and notify times; owes replies in order.
    class allowlist_mirror;
        logic [N_USERS-1:0] accepts [N_USERS];
        logic [CNT_W-1:0]   accept_count [N_USERS];
        logic [TIME_W-1:0]  notified_at [N_USERS];
        logic [CNT_W-1:0]   cap;
        logic               keep_on_nick;
        logic [CD_W-1:0]    cooldown;
        t_reply             owed_replies [$];
        int                 mismatch_count;

        function new();
            for (int i = 0; i < N_USERS; i++) begin
                accepts[i]      = '0;
                accept_count[i] = '0;
                notified_at[i]  = '0;
            end
            cap            = MAX_ACCEPTS_RST;
            keep_on_nick   = TRACK_NICK_RST;
            cooldown       = COOLDOWN_RST;
            mismatch_count = 0;
        endfunction

        function void take_config(logic [CIDX_W-1:0] index, logic [CD_W-1:0] data);
            case (index)
                CFG_MAX_ACCEPTS: cap = data[CNT_W-1:0];
                CFG_TRACK_NICK:  keep_on_nick = data[0];
                CFG_COOLDOWN:    cooldown = data;
                default: ;
            endcase
        endfunction

        function void owe(t_status status, logic notify, logic [ID_W-1:0] entry, logic last);
            t_reply r;
            r.status   = status;
            r.notify   = notify;
            r.entry_id = entry;
            r.last     = last;
            owed_replies = {owed_replies, r};
        endfunction

        function void drop_everywhere(logic [ID_W-1:0] who);
            for (int i = 0; i < N_USERS; i++) begin
                if (accepts[i][who]) begin
                    accepts[i][who] = 1'b0;
                    accept_count[i] = accept_count[i] - 1'b1;
                end
            end
        endfunction

        function void take_request(t_request rq);
            logic [TIME_W:0] deadline;
            case (rq.action)
                ACT_ADD: begin
                    if (!rq.other_valid) begin
                        owe(ST_NOUSER, 1'b0, '0, 1'b1);
                    end else if (accept_count[rq.user_id] >= cap) begin
                        owe(ST_FULL, 1'b0, '0, 1'b1);
                    end else if (accepts[rq.user_id][rq.other_id]) begin
                        owe(ST_EXIST, 1'b0, '0, 1'b1);
                    end else begin
                        accepts[rq.user_id][rq.other_id] = 1'b1;
                        accept_count[rq.user_id] = accept_count[rq.user_id] + 1'b1;
                        owe(ST_OK, 1'b0, '0, 1'b1);
                    end
                end
                ACT_REMOVE: begin
                    if (!rq.other_valid) begin
                        owe(ST_NOUSER, 1'b0, '0, 1'b1);
                    end else if (!accepts[rq.user_id][rq.other_id]) begin
                        owe(ST_NOT, 1'b0, '0, 1'b1);
                    end else begin
                        accepts[rq.user_id][rq.other_id] = 1'b0;
                        accept_count[rq.user_id] = accept_count[rq.user_id] - 1'b1;
                        owe(ST_OK, 1'b0, '0, 1'b1);
                    end
                end
                ACT_LIST: begin
                    for (int i = 0; i < N_USERS; i++)
                        if (accepts[rq.user_id][i]) owe(ST_ENTRY, 1'b0, ID_W'(i), 1'b0);
                    owe(ST_END, 1'b0, '0, 1'b1);
                end
                ACT_CHECK: begin
                    // The sum is one bit wider, so it never wraps.
                    deadline = {1'b0, notified_at[rq.other_id]} + {17'd0, cooldown};
                    if (!rq.sender_local || !rq.dest_has_mode || rq.user_id == rq.other_id
                        || rq.sender_privileged || accepts[rq.other_id][rq.user_id]) begin
                        owe(ST_PASS, 1'b0, '0, 1'b1);
                    end else if ({1'b0, rq.now} > deadline) begin
                        notified_at[rq.other_id] = rq.now;
                        owe(ST_DENY, 1'b1, '0, 1'b1);
                    end else begin
                        owe(ST_DENY, 1'b0, '0, 1'b1);
                    end
                end
                ACT_QUIT: begin
                    drop_everywhere(rq.user_id);
                    accepts[rq.user_id]      = '0;
                    accept_count[rq.user_id] = '0;
                    notified_at[rq.user_id]  = '0;
                    owe(ST_OK, 1'b0, '0, 1'b1);
                end
                ACT_NICK: begin
                    if (!keep_on_nick) drop_everywhere(rq.user_id);
                    owe(ST_OK, 1'b0, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void match_reply(t_reply got);
            t_reply want;
            if (owed_replies.size() == 0) begin
                $error("reply with nothing owed: status %0d entry_id %0d last %0d",
                       got.status, got.entry_id, got.last);
                mismatch_count++;
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.notify !== want.notify) begin
                $error("notify: expected %0d, actual %0d", want.notify, got.notify);
                mismatch_count++;
            end
            if (got.entry_id !== want.entry_id) begin
                $error("entry_id: expected %0d, actual %0d", want.entry_id, got.entry_id);
                mismatch_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatch_count++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cal_req_if req_ch ();
    cal_rsp_if rsp_ch ();
    cal_cfg_if cfg_ch ();

    caller_allowlist_filter_top #(
        .MAX_USERS (N_USERS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    allowlist_mirror mirror = new();

    // Per-phase knobs for the request sender and the reply receiver.
    bit                req_gaps_on;
    bit                rsp_stalls_on;
    int                burst_left;
    // Running time base for message checks, so cooldowns are actually crossed.
    logic [TIME_W-1:0] wall_clock;
    int                clock_step_max;
    int                cycle_count = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Watch all three channels at the edge; values read here are the ones
    // sampled by the block, since every driver uses nonblocking updates.
    // Check a reply before noting a request: a request never answers in the
    // cycle it is taken.
    always @(posedge i_clk) begin : watch
        t_reply   got;
        t_request rq;
        if (i_rst_n) begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                got.status   = rsp_ch.status;
                got.notify   = rsp_ch.notify;
                got.entry_id = rsp_ch.entry_id;
                got.last     = rsp_ch.last;
                mirror.match_reply(got);
            end
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
                rq.action            = req_ch.action;
                rq.user_id           = req_ch.user_id;
                rq.other_id          = req_ch.other_id;
                rq.other_valid       = req_ch.other_valid;
                rq.sender_local      = req_ch.sender_local;
                rq.dest_has_mode     = req_ch.dest_has_mode;
                rq.sender_privileged = req_ch.sender_privileged;
                rq.now               = req_ch.now;
                mirror.take_request(rq);
            end
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
                mirror.take_config(cfg_ch.index, cfg_ch.data);
        end
    end

    // Reply receiver: alternate open and stalled windows of random length,
    // or stay open for the whole phase when stalls are off.
    initial begin : reply_pacing
        int hold;
        bit open;
        hold = 0;
        open = 1'b1;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!rsp_stalls_on) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                if (hold == 0) begin
                    open = !open;
                    hold = open ? $urandom_range(1, 12) : $urandom_range(1, 7);
                end
                hold--;
                rsp_ch.ready <= open;
            end
        end
    end

    function automatic logic [ID_W-1:0] pick_id();
        // Favor a few ids so adds, removes and checks hit the same entries.
        if ($urandom_range(0, 9) < 7) return ID_W'($urandom_range(0, 5));
        return ID_W'($urandom());
    endfunction

    function automatic t_request request_of(logic [ACT_W-1:0] action, logic [ID_W-1:0] uid,
                                            logic [ID_W-1:0] oid, logic ovalid, logic sloc,
                                            logic mode, logic priv, logic [TIME_W-1:0] now);
        t_request rq;
        rq.action            = action;
        rq.user_id           = uid;
        rq.other_id          = oid;
        rq.other_valid       = ovalid;
        rq.sender_local      = sloc;
        rq.dest_has_mode     = mode;
        rq.sender_privileged = priv;
        rq.now               = now;
        return rq;
    endfunction

    function automatic t_request make_request();
        t_request rq;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      rq.action = ACT_ADD;
        else if (pick < 45) rq.action = ACT_REMOVE;
        else if (pick < 54) rq.action = ACT_LIST;
        else if (pick < 85) rq.action = ACT_CHECK;
        else if (pick < 90) rq.action = ACT_QUIT;
        else if (pick < 96) rq.action = ACT_NICK;
        else                rq.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        rq.user_id  = pick_id();
        rq.other_id = pick_id();
        // Bias the flags toward the deny path so cooldowns get exercised.
        rq.other_valid       = $urandom_range(0, 9) != 0;
        rq.sender_local      = $urandom_range(0, 6) != 0;
        rq.dest_has_mode     = $urandom_range(0, 6) != 0;
        rq.sender_privileged = $urandom_range(0, 9) == 0;
        if (rq.action == ACT_CHECK) begin
            if ($urandom_range(0, 19) == 0) wall_clock = $urandom();
            else wall_clock = wall_clock + TIME_W'($urandom_range(0, clock_step_max));
            rq.now = wall_clock;
        end else begin
            rq.now = $urandom();
        end
        return rq;
    endfunction

    // Offer one request; drop valid for a random gap between bursts.
    task automatic send_request(input t_request rq);
        if (req_gaps_on && burst_left <= 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        req_ch.valid             <= 1'b1;
        req_ch.action            <= rq.action;
        req_ch.user_id           <= rq.user_id;
        req_ch.other_id          <= rq.other_id;
        req_ch.other_valid       <= rq.other_valid;
        req_ch.sender_local      <= rq.sender_local;
        req_ch.dest_has_mode     <= rq.dest_has_mode;
        req_ch.sender_privileged <= rq.sender_privileged;
        req_ch.now               <= rq.now;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        burst_left--;
    endtask

    // Drop valid, wait until every owed reply is in, then hold off long
    // enough for an ignored request or a purge sweep to finish.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (mirror.owed_replies.size() != 0) @(posedge i_clk);
        repeat (CLOSE_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] index, input logic [CD_W-1:0] data);
        // Advance one edge first so back-to-back writes never lower and
        // raise valid in the same step.
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reconfigure while idle, then run random requests. With fill set, first
    // build one owner's full list, overflow it, list it and purge one entry.
    task automatic run_phase(input logic [CNT_W-1:0] cap, input logic keep,
                             input logic [CD_W-1:0] cd, input bit gaps, input bit stalls,
                             input bit fill);
        logic [ID_W-1:0] owner;
        logic [ID_W-1:0] order [N_USERS];
        logic [ID_W-1:0] swap;
        int              j;
        t_request        rq;
        settle();
        write_reg(CFG_MAX_ACCEPTS, {{(CD_W-CNT_W){1'b0}}, cap});
        write_reg(CFG_TRACK_NICK, {{(CD_W-1){1'b0}}, keep});
        write_reg(CFG_COOLDOWN, cd);
        req_gaps_on    = gaps;
        rsp_stalls_on  = stalls;
        clock_step_max = 2 * int'(cd) + 3;
        if (fill) begin
            owner = ID_W'($urandom());
            for (int i = 0; i < N_USERS; i++) order[i] = ID_W'(i);
            for (int i = N_USERS - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                swap     = order[i];
                order[i] = order[j];
                order[j] = swap;
            end
            rq = make_request();
            rq.action  = ACT_QUIT;
            rq.user_id = owner;
            send_request(rq);
            for (int i = 0; i <= N_USERS; i++) begin
                rq = make_request();
                rq.action      = ACT_ADD;
                rq.user_id     = owner;
                rq.other_id    = (i < N_USERS) ? order[i] : pick_id();
                rq.other_valid = 1'b1;
                send_request(rq);
            end
            rq = make_request();
            rq.action  = ACT_LIST;
            rq.user_id = owner;
            send_request(rq);
            rq = make_request();
            rq.action  = ACT_NICK;
            rq.user_id = order[0];
            send_request(rq);
        end
        repeat (RANDOM_PER_PHASE) send_request(make_request());
    endtask

    initial begin : main
        // Drive every input to a known value before the first edge.
        i_rst_n                  <= 1'b0;
        req_ch.valid             <= 1'b0;
        req_ch.action            <= ACT_ADD;
        req_ch.user_id           <= '0;
        req_ch.other_id          <= '0;
        req_ch.other_valid       <= 1'b0;
        req_ch.sender_local      <= 1'b0;
        req_ch.dest_has_mode     <= 1'b0;
        req_ch.sender_privileged <= 1'b0;
        req_ch.now               <= '0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.index             <= CFG_MAX_ACCEPTS;
        cfg_ch.data              <= '0;
        req_gaps_on    = 1'b1;
        rsp_stalls_on  = 1'b1;
        burst_left     = 0;
        wall_clock     = '0;
        clock_step_max = 123;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset configuration.
        // Empty list gives only the end marker.
        send_request(request_of(ACT_LIST, 5'd0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        // Unregistered target, then add, duplicate, self entry.
        send_request(request_of(ACT_ADD, 5'd0, 5'd31, 1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_request(request_of(ACT_ADD, 5'd0, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(request_of(ACT_ADD, 5'd0, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0));
        send_request(request_of(ACT_ADD, 5'd0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(request_of(ACT_ADD, 5'd31, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(request_of(ACT_LIST, 5'd0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        // Remove an absent entry, and remove with an unregistered target.
        send_request(request_of(ACT_REMOVE, 5'd0, 5'd5, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(request_of(ACT_REMOVE, 5'd0, 5'd31, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
        // Each pass rule on its own: remote, no mode, self, privileged, listed.
        send_request(request_of(ACT_CHECK, 5'd5, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0, 32'd500));
        send_request(request_of(ACT_CHECK, 5'd5, 5'd0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd500));
        send_request(request_of(ACT_CHECK, 5'd9, 5'd9, 1'b1, 1'b1, 1'b1, 1'b0, 32'd500));
        send_request(request_of(ACT_CHECK, 5'd5, 5'd0, 1'b1, 1'b1, 1'b1, 1'b1, 32'd500));
        send_request(request_of(ACT_CHECK, 5'd31, 5'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd500));
        // Deny at the cooldown boundary, just past it, inside the next window.
        send_request(request_of(ACT_CHECK, 5'd7, 5'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd60));
        send_request(request_of(ACT_CHECK, 5'd7, 5'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd61));
        send_request(request_of(ACT_CHECK, 5'd7, 5'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd121));
        // Top of the time range: the limit must not wrap.
        send_request(request_of(ACT_CHECK, 5'd7, 5'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF));
        send_request(request_of(ACT_CHECK, 5'd7, 5'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF));
        // Nick change without tracking purges id 0 from every row.
        send_request(request_of(ACT_NICK, 5'd0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(request_of(ACT_LIST, 5'd31, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(request_of(ACT_REMOVE, 5'd0, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        // Quit frees the slot, notify time included.
        send_request(request_of(ACT_QUIT, 5'd0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0));
        send_request(request_of(ACT_CHECK, 5'd7, 5'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'd61));
        // Spare action codes: no reply.
        send_request(request_of(ACT_SPARE_LO, 5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1,
                                32'hFFFF_FFFF));
        send_request(request_of(ACT_SPARE_HI, 5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1,
                                32'hFFFF_FFFF));

        // Random phases: low extremes, high extremes with a full list, a tight
        // list, a random setting, and back to the reset values.
        run_phase(6'd0, 1'b1, 16'd0, 1'b1, 1'b1, 1'b0);
        run_phase(6'd32, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        run_phase(6'd3, 1'b1, 16'd5, 1'b1, 1'b0, 1'b0);
        run_phase(CNT_W'($urandom_range(0, 32)), 1'($urandom_range(0, 1)),
                  CD_W'($urandom()), 1'b0, 1'b1, 1'b0);
        run_phase(MAX_ACCEPTS_RST, TRACK_NICK_RST, COOLDOWN_RST, 1'b1, 1'b1, 1'b0);

        settle();
        if (mirror.mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
